### rtl/core/braille_cell_binner_assert.svh
// Assertion macros used by the checker file of the braille cell binner.
`ifndef BRAILLE_CELL_BINNER_ASSERT_SVH
`define BRAILLE_CELL_BINNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BCB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("braille_cell_binner: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("braille_cell_binner: next-cycle check failed");

`endif

### rtl/core/bcb_pkg.sv
`default_nettype none

package bcb_pkg;

  // Default plot limits in dots.
  localparam int MAX_DOT_COLS_DEF = 512;
  localparam int MAX_DOT_ROWS_DEF = 256;

  // Field widths of the channels.
  localparam int COORD_W = 11;
  localparam int LEVEL_W = 13;
  localparam int AGE_W   = 16;
  localparam int DOTS_W  = 8;
  localparam int COL_OUT_W = 8;
  localparam int ROW_OUT_W = 6;

  // Configuration registers.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int PLOT_W_W   = 10;
  localparam int PLOT_H_W   = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_PLOT_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLOT_HEIGHT = 1'b1;
  localparam logic [PLOT_W_W-1:0]  PLOT_WIDTH_RST  = 10'd512;
  localparam logic [PLOT_H_W-1:0]  PLOT_HEIGHT_RST = 9'd256;

  // One word of the cell store.
  typedef struct packed {
    logic [DOTS_W-1:0]         dots;
    logic signed [LEVEL_W-1:0] level;
    logic [AGE_W-1:0]          age;
  } cell_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic accept;
    logic clear;
    logic pt_write;
    logic scan_adv;
    logic scan_take;
    logic scan_none;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_drain;
    logic pt_ok;
    logic scan_end;
    logic scan_hit;
    logic clr_done;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/bcb_ctrl.sv
`default_nettype none

module bcb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  bcb_pkg::sts_t sts,
  output bcb_pkg::cmd_t cmd
);
  import bcb_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_PT_WR = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  // Items are taken only in the idle state.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Command decode.
  always_comb begin
    cmd           = '0;
    cmd.idle      = (state == ST_IDLE);
    cmd.accept    = accept;
    cmd.clear     = (state == ST_CLEAR);
    cmd.pt_write  = (state == ST_PT_WR);
    cmd.scan_adv  = (state == ST_SCAN) && !sts.scan_end && !sts.scan_hit;
    cmd.scan_take = (state == ST_SCAN) && sts.scan_hit && out_free;
    cmd.scan_none = (state == ST_SCAN) && sts.scan_end && out_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (sts.is_drain) state_next = ST_SCAN;
          else if (sts.pt_ok) state_next = ST_PT_WR;
        end
      end
      ST_PT_WR: begin
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (cmd.scan_take || cmd.scan_none) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // The output register is full from a load until its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.scan_take || cmd.scan_none) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bcb_datapath.sv
`default_nettype none

module bcb_datapath #(
  parameter int MAX_DOT_COLS = bcb_pkg::MAX_DOT_COLS_DEF,
  parameter int MAX_DOT_ROWS = bcb_pkg::MAX_DOT_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bcb_pkg::cmd_t                        cmd,
  output bcb_pkg::sts_t                        sts,
  input  logic                                 cfg_valid,
  input  logic [bcb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bcb_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 req_type,
  input  logic signed [bcb_pkg::COORD_W-1:0]   dot_x,
  input  logic signed [bcb_pkg::COORD_W-1:0]   dot_y,
  input  logic signed [bcb_pkg::LEVEL_W-1:0]   level_db,
  input  logic [bcb_pkg::AGE_W-1:0]           age_ms,
  output logic                                 found,
  output logic [bcb_pkg::COL_OUT_W-1:0]       cell_col,
  output logic [bcb_pkg::ROW_OUT_W-1:0]       cell_row,
  output logic [bcb_pkg::DOTS_W-1:0]          dot_bits,
  output logic signed [bcb_pkg::LEVEL_W-1:0]   cell_db,
  output logic [bcb_pkg::AGE_W-1:0]           cell_age
);
  import bcb_pkg::*;

  localparam int CELL_COLS  = (MAX_DOT_COLS + 1) / 2;
  localparam int CELL_ROWS  = (MAX_DOT_ROWS + 3) / 4;
  localparam int CELL_COUNT = CELL_COLS * CELL_ROWS;
  localparam int IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int PTR_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = (CELL_COLS > 1) ? $clog2(CELL_COLS) : 1;
  localparam int ROW_W      = $clog2(CELL_ROWS + 1);
  localparam int LIM_MAX    = (MAX_DOT_COLS > MAX_DOT_ROWS) ? MAX_DOT_COLS : MAX_DOT_ROWS;
  localparam int LIM_W      = $clog2(LIM_MAX + 1);
  localparam int CMP_W      = ((LIM_W > COORD_W) ? LIM_W : COORD_W) + 1;
  localparam int MUL_W      = PTR_W + COORD_W;

  // Configuration registers.
  logic [PLOT_W_W-1:0] plot_width;
  logic [PLOT_H_W-1:0] plot_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      plot_width  <= PLOT_WIDTH_RST;
      plot_height <= PLOT_HEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PLOT_WIDTH) plot_width <= cfg_data[PLOT_W_W-1:0];
      if (cfg_index == CFG_PLOT_HEIGHT) plot_height <= cfg_data[PLOT_H_W-1:0];
    end
  end

  // Range check of the point against the clamped plot size.
  logic [CMP_W-1:0] w_lim;
  logic [CMP_W-1:0] h_lim;
  logic             x_ok;
  logic             y_ok;
  logic [MUL_W-1:0] row_base;
  logic [IDX_W-1:0] pt_idx;
  logic [2:0]       pt_bit;

  always_comb begin
    w_lim = (CMP_W'(plot_width) > CMP_W'(MAX_DOT_COLS)) ? CMP_W'(MAX_DOT_COLS)
                                                        : CMP_W'(plot_width);
    h_lim = (CMP_W'(plot_height) > CMP_W'(MAX_DOT_ROWS)) ? CMP_W'(MAX_DOT_ROWS)
                                                         : CMP_W'(plot_height);
    x_ok  = !dot_x[COORD_W-1] && (CMP_W'(dot_x[COORD_W-2:0]) < w_lim);
    y_ok  = !dot_y[COORD_W-1] && (CMP_W'(dot_y[COORD_W-2:0]) < h_lim);
  end

  // Cell index of the point: row-major with a fixed row stride.
  assign row_base = MUL_W'(dot_y[COORD_W-2:2]) * MUL_W'(CELL_COLS);
  assign pt_idx   = IDX_W'(row_base + MUL_W'(dot_x[COORD_W-2:1]));
  assign pt_bit   = {dot_y[1:0], dot_x[0]};

  // Point held for the read-modify-write.
  logic [IDX_W-1:0]         p_idx;
  logic [2:0]               p_bit;
  logic signed [LEVEL_W-1:0] p_lev;
  logic [AGE_W-1:0]         p_age;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_idx <= pt_idx;
      p_bit <= pt_bit;
      p_lev <= level_db;
      p_age <= age_ms;
    end
  end

  // Drain pointer, kept with its column and row so no division is needed.
  logic [PTR_W-1:0] drain_ptr;
  logic [COL_W-1:0] drain_col;
  logic [ROW_W-1:0] drain_row;
  logic [PTR_W-1:0] chk_ptr;
  logic [COL_W-1:0] chk_col;
  logic [ROW_W-1:0] chk_row;
  logic [PTR_W-1:0] chk_ptr_next;
  logic [COL_W-1:0] chk_col_next;
  logic [ROW_W-1:0] chk_row_next;
  logic             col_wrap;

  assign col_wrap     = (chk_col == COL_W'(CELL_COLS - 1));
  assign chk_ptr_next = chk_ptr + PTR_W'(1);
  assign chk_col_next = col_wrap ? '0 : chk_col + COL_W'(1);
  assign chk_row_next = col_wrap ? chk_row + ROW_W'(1) : chk_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_ptr <= '0;
      drain_col <= '0;
      drain_row <= '0;
    end else if (cmd.scan_take) begin
      drain_ptr <= chk_ptr_next;
      drain_col <= chk_col_next;
      drain_row <= chk_row_next;
    end else if (cmd.scan_none) begin
      drain_ptr <= '0;
      drain_col <= '0;
      drain_row <= '0;
    end
  end

  // Scan position: the cell whose word is on the read port this cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept && req_type) begin
      chk_ptr <= drain_ptr;
      chk_col <= drain_col;
      chk_row <= drain_row;
    end else if (cmd.scan_adv) begin
      chk_ptr <= chk_ptr_next;
      chk_col <= chk_col_next;
      chk_row <= chk_row_next;
    end
  end

  // Clearing pass counter.
  logic [IDX_W-1:0] clr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clear) begin
      clr_ptr <= clr_ptr + IDX_W'(1);
    end
  end

  // Cell store with one write port and one registered read port.
  cell_t            mem [CELL_COUNT];
  cell_t            rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  cell_t            wr_data;
  cell_t            merged;
  logic             take_new;
  logic             lev_new;

  always_comb begin
    if (cmd.scan_adv) rd_addr = chk_ptr_next[IDX_W-1:0];
    else if (cmd.idle) rd_addr = req_type ? drain_ptr[IDX_W-1:0] : pt_idx;
    else rd_addr = chk_ptr[IDX_W-1:0];
  end

  // Merge of a point into its cell: the younger point wins, at equal age
  // the larger level.
  always_comb begin
    take_new     = (rd_data.dots == '0) || (p_age < rd_data.age);
    lev_new      = take_new || ((p_age == rd_data.age) && (p_lev > rd_data.level));
    merged.dots  = rd_data.dots | (DOTS_W'(1) << p_bit);
    merged.level = lev_new ? p_lev : rd_data.level;
    merged.age   = take_new ? p_age : rd_data.age;
  end

  // Write port select.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_idx;
    wr_data = merged;
    if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_ptr;
      wr_data = '0;
    end else if (cmd.pt_write) begin
      wr_en   = 1'b1;
    end else if (cmd.scan_take) begin
      wr_en        = 1'b1;
      wr_addr      = chk_ptr[IDX_W-1:0];
      wr_data      = rd_data;
      wr_data.dots = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Status toward the controller.
  always_comb begin
    sts          = '0;
    sts.is_drain = req_type;
    sts.pt_ok    = x_ok && y_ok;
    sts.scan_end = (chk_ptr == PTR_W'(CELL_COUNT));
    sts.scan_hit = !sts.scan_end && (rd_data.dots != '0);
    sts.clr_done = (clr_ptr == IDX_W'(CELL_COUNT - 1));
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.scan_take) begin
      found    <= 1'b1;
      cell_col <= COL_OUT_W'(chk_col);
      cell_row <= ROW_OUT_W'(chk_row);
      dot_bits <= rd_data.dots;
      cell_db  <= rd_data.level;
      cell_age <= rd_data.age;
    end else if (cmd.scan_none) begin
      found    <= 1'b0;
      cell_col <= '0;
      cell_row <= '0;
      dot_bits <= '0;
      cell_db  <= '0;
      cell_age <= '0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/braille_cell_binner.sv
`default_nettype none

// Braille cell binner. Plot points are binned into 2x4 dot cells held in an
// on-chip cell store, and drain requests return occupied cells in row-major
// order, clearing each one as it goes out. A point is accepted and then goes
// through the read-modify-write of its cell through the single write port of
// the store; a point outside the plot is dropped at accept. A drain scans
// from its start position, reading one cell per cycle from the store's read
// port, until it finds an occupied cell or reaches the end of the store; it
// then waits while the output register is still full and stalled. A
// finished result sits in an output register, so points keep flowing while
// it waits to be taken. After reset a clearing pass writes every cell once
// (CELL_COUNT cells, 16384 at default sizes), with in_stall high;
// configuration writes are taken at any time and cfg_ready is always high.

module braille_cell_binner #(
  parameter int MAX_DOT_COLS = bcb_pkg::MAX_DOT_COLS_DEF,
  parameter int MAX_DOT_ROWS = bcb_pkg::MAX_DOT_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bcb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bcb_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 req_type,
  input  logic signed [bcb_pkg::COORD_W-1:0]   dot_x,
  input  logic signed [bcb_pkg::COORD_W-1:0]   dot_y,
  input  logic signed [bcb_pkg::LEVEL_W-1:0]   level_db,
  input  logic [bcb_pkg::AGE_W-1:0]           age_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 found,
  output logic [bcb_pkg::COL_OUT_W-1:0]       cell_col,
  output logic [bcb_pkg::ROW_OUT_W-1:0]       cell_row,
  output logic [bcb_pkg::DOTS_W-1:0]          dot_bits,
  output logic signed [bcb_pkg::LEVEL_W-1:0]   cell_db,
  output logic [bcb_pkg::AGE_W-1:0]           cell_age
);
  import bcb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Register writes never wait.
  assign cfg_ready = 1'b1;

  // Sequencer.
  bcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Cell store, pointers and result register.
  bcb_datapath #(
    .MAX_DOT_COLS (MAX_DOT_COLS),
    .MAX_DOT_ROWS (MAX_DOT_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .dot_x     (dot_x),
    .dot_y     (dot_y),
    .level_db  (level_db),
    .age_ms    (age_ms),
    .found     (found),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .dot_bits  (dot_bits),
    .cell_db   (cell_db),
    .cell_age  (cell_age)
  );

endmodule

`default_nettype wire

### rtl/core/braille_cell_binner_chk.sv
`default_nettype none

`include "braille_cell_binner_assert.svh"

module braille_cell_binner_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 req_type,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 found,
  input logic [bcb_pkg::COL_OUT_W-1:0]       cell_col,
  input logic [bcb_pkg::ROW_OUT_W-1:0]       cell_row,
  input logic [bcb_pkg::DOTS_W-1:0]          dot_bits,
  input logic signed [bcb_pkg::LEVEL_W-1:0]   cell_db,
  input logic [bcb_pkg::AGE_W-1:0]           cell_age
);
  import bcb_pkg::*;

  // An empty drain result carries all-zero fields.
  `BCB_ASSERT_NOW(a_empty_zero, clk, rst, out_valid && !found,
    cell_col == '0 && cell_row == '0 && dot_bits == '0 && cell_db == '0 && cell_age == '0)

  // A returned cell always has at least one dot.
  `BCB_ASSERT_NOW(a_found_dots, clk, rst, out_valid && found, dot_bits != '0)

  // A stalled result beat stays in place.
  `BCB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(found) && $stable(dot_bits) && $stable(cell_age))

  // A drain always occupies the block for at least the next cycle.
  `BCB_ASSERT_NEXT(a_drain_busy, clk, rst, in_valid && !in_stall && req_type, in_stall)

endmodule

bind braille_cell_binner braille_cell_binner_chk u_chk (.*);

`default_nettype wire

### tb/sv/braille_cell_binner_checker.sv
`timescale 1ns / 100ps

module braille_cell_binner_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [bcb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bcb_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 req_type,
  input  logic signed [bcb_pkg::COORD_W-1:0]   dot_x,
  input  logic signed [bcb_pkg::COORD_W-1:0]   dot_y,
  input  logic signed [bcb_pkg::LEVEL_W-1:0]   level_db,
  input  logic [bcb_pkg::AGE_W-1:0]            age_ms,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic                                 found,
  input  logic [bcb_pkg::COL_OUT_W-1:0]        cell_col,
  input  logic [bcb_pkg::ROW_OUT_W-1:0]        cell_row,
  input  logic [bcb_pkg::DOTS_W-1:0]           dot_bits,
  input  logic signed [bcb_pkg::LEVEL_W-1:0]   cell_db,
  input  logic [bcb_pkg::AGE_W-1:0]            cell_age,
  output int                                   mismatches,
  output int                                   outstanding
);

  import bcb_pkg::*;

  localparam logic REQ_DRAIN = 1'b1;

  localparam int CELL_COLS  = (MAX_DOT_COLS_DEF + 1) / 2;
  localparam int CELL_ROWS  = (MAX_DOT_ROWS_DEF + 3) / 4;
  localparam int CELL_COUNT = CELL_COLS * CELL_ROWS;
  localparam int REPORT_LIMIT = 10;

  // One drain result as it leaves the block.
  typedef struct packed {
    logic                      found;
    logic [COL_OUT_W-1:0]      col;
    logic [ROW_OUT_W-1:0]      row;
    logic [DOTS_W-1:0]         dots;
    logic signed [LEVEL_W-1:0] db;
    logic [AGE_W-1:0]          age;
  } cell_report_t;

  // Shadow copy of the cell store, the scan position and the plot size.
  logic [DOTS_W-1:0]         dots_mem  [CELL_COUNT];
  logic signed [LEVEL_W-1:0] level_mem [CELL_COUNT];
  logic [AGE_W-1:0]          age_mem   [CELL_COUNT];
  int                        scan_ptr;
  logic [PLOT_W_W-1:0]       width_reg;
  logic [PLOT_H_W-1:0]       height_reg;

  // Drain results still owed by the block, oldest first.
  cell_report_t pending_cells[$];

  initial mismatches = 0;
  initial outstanding = 0;

  // Bins one point into its cell; points off the plot leave the store alone.
  function automatic void bin_point(input int x, input int y,
                                    input logic signed [LEVEL_W-1:0] lev,
                                    input logic [AGE_W-1:0] age);
    int w_lim, h_lim, idx, bitpos;
    w_lim = (width_reg > MAX_DOT_COLS_DEF) ? MAX_DOT_COLS_DEF : int'(width_reg);
    h_lim = (height_reg > MAX_DOT_ROWS_DEF) ? MAX_DOT_ROWS_DEF : int'(height_reg);
    if (x < 0 || x >= w_lim || y < 0 || y >= h_lim)
      return;
    idx    = (y / 4) * CELL_COLS + x / 2;
    bitpos = (y % 4) * 2 + x % 2;
    // A younger point, or the first one, owns the cell; a tie keeps the louder level.
    if (dots_mem[idx] == '0 || age < age_mem[idx]) begin
      level_mem[idx] = lev;
      age_mem[idx]   = age;
    end else if (age == age_mem[idx] && lev > level_mem[idx]) begin
      level_mem[idx] = lev;
    end
    dots_mem[idx][bitpos] = 1'b1;
  endfunction

  // Finds the next occupied cell from the scan position and clears it.
  function automatic cell_report_t drain_next_cell();
    cell_report_t r;
    int i;
    r = '0;
    for (i = scan_ptr; i < CELL_COUNT; i++) begin
      if (dots_mem[i] != '0) begin
        r.found = 1'b1;
        r.col   = COL_OUT_W'(i % CELL_COLS);
        r.row   = ROW_OUT_W'(i / CELL_COLS);
        r.dots  = dots_mem[i];
        r.db    = level_mem[i];
        r.age   = age_mem[i];
        dots_mem[i] = '0;
        scan_ptr = i + 1;
        return r;
      end
    end
    // Nothing left: the next drain starts a new pass from the first cell.
    scan_ptr = 0;
    return r;
  endfunction

  always @(posedge clk) begin
    cell_report_t got, want;
    if (rst) begin
      for (int i = 0; i < CELL_COUNT; i++) begin
        dots_mem[i]  = '0;
        level_mem[i] = '0;
        age_mem[i]   = '0;
      end
      scan_ptr   = 0;
      width_reg  = PLOT_WIDTH_RST;
      height_reg = PLOT_HEIGHT_RST;
      pending_cells.delete();
    end else begin
      // Result beat: compare with the oldest drain still waiting.
      if (out_valid && !out_stall) begin
        got = '{found, cell_col, cell_row, dot_bits, cell_db, cell_age};
        if (pending_cells.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result beat with no drain waiting: found=%0d col=%0d row=%0d",
                     $time, got.found, got.col, got.row);
          mismatches++;
        end else begin
          want = pending_cells.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: drain result mismatch", $time);
              $display("  exp found=%0d col=%0d row=%0d dots=%02h db=%0d age=%0d",
                       want.found, want.col, want.row, want.dots, want.db, want.age);
              $display("  got found=%0d col=%0d row=%0d dots=%02h db=%0d age=%0d",
                       got.found, got.col, got.row, got.dots, got.db, got.age);
            end
            mismatches++;
          end
        end
      end
      // Request beat: update the shadow store, queue a result for a drain.
      if (in_valid && !in_stall) begin
        if (req_type == REQ_DRAIN)
          pending_cells.insert(pending_cells.size(), drain_next_cell());
        else
          bin_point(dot_x, dot_y, level_db, age_ms);
      end
      // Register write beat.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PLOT_WIDTH:  width_reg  = cfg_data[PLOT_W_W-1:0];
          CFG_PLOT_HEIGHT: height_reg = cfg_data[PLOT_H_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = pending_cells.size();
  end

endmodule

### tb/sv/braille_cell_binner_tb.sv
`timescale 1ns / 100ps

module braille_cell_binner_tb;

  import bcb_pkg::*;

  localparam logic REQ_POINT = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int PHASE_COUNT    = 7;
  localparam int PHASE_BEATS    = 72;
  localparam int PRESSURE_PHASE = 4;
  localparam int LONG_HOLD      = 20000;
  localparam int EMPTY_CAP      = 1;
  localparam int SETTLE         = 4;
  localparam int DRAIN_TAIL     = 20;

  logic clk;
  logic rst = 1'b1;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data  = '0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      req_type = REQ_POINT;
  logic signed [COORD_W-1:0] dot_x    = '0;
  logic signed [COORD_W-1:0] dot_y    = '0;
  logic signed [LEVEL_W-1:0] level_db = '0;
  logic [AGE_W-1:0]          age_ms   = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      found;
  logic [COL_OUT_W-1:0]      cell_col;
  logic [ROW_OUT_W-1:0]      cell_row;
  logic [DOTS_W-1:0]         dot_bits;
  logic signed [LEVEL_W-1:0] cell_db;
  logic [AGE_W-1:0]          cell_age;

  int mismatches;
  int outstanding;

  // Stimulus shaping state shared by the sender and the receiver.
  int empties = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int unsigned stall_left = 0;

  // Plot sizes per phase: above maximum, zero width, minimum, zero height,
  // full size, small odd, and a middle size.
  int plot_w_tbl [PHASE_COUNT] = '{1023, 0, 1, 512, 512, 3, 77};
  int plot_h_tbl [PHASE_COUNT] = '{511, 256, 1, 0, 256, 7, 130};

  braille_cell_binner dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .req_type, .dot_x, .dot_y, .level_db, .age_ms,
    .out_valid, .out_stall, .found, .cell_col, .cell_row, .dot_bits,
    .cell_db, .cell_age
  );

  braille_cell_binner_checker checker_i (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .req_type, .dot_x, .dot_y, .level_db, .age_ms,
    .out_valid, .out_stall, .found, .cell_col, .cell_row, .dot_bits,
    .cell_db, .cell_age, .mismatches, .outstanding
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Count drains that came back empty, so each phase pays for few full scans.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall && !found)
      empties <= empties + 1;
  end

  // Mostly short gaps, now and then a long one, none at all in calm phases.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, plus one long hold-off while requests keep coming.
  // The hold-off starts once a result is waiting and outlasts a full scan, so a
  // later drain is left waiting behind it with the input stalled.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b0;
        while (!out_valid)
          @(negedge clk);
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = gap_len();
      end
    end
  end

  task automatic idle_in(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Offers one request beat and waits until the block takes it.
  task automatic send_beat(input logic kind, input int x, input int y,
                           input int lev, input int age);
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= kind;
    dot_x    <= x[COORD_W-1:0];
    dot_y    <= y[COORD_W-1:0];
    level_db <= lev[LEVEL_W-1:0];
    age_ms   <= age[AGE_W-1:0];
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  task automatic send_point(input int x, input int y, input int lev, input int age);
    send_beat(REQ_POINT, x, y, lev, age);
    idle_in(gap_len());
  endtask

  task automatic send_drain();
    send_beat(REQ_DRAIN, $urandom, $urandom, $urandom, $urandom);
    idle_in(gap_len());
  endtask

  // Writes both plot size registers back to back.
  task automatic write_plot(input int w, input int h);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PLOT_WIDTH;
    cfg_data  <= w[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_index <= CFG_PLOT_HEIGHT;
    cfg_data  <= h[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops sending until every drain has answered and the last point has landed.
  task automatic wait_idle();
    idle_in(1);
    while (outstanding != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mostly points around one cell, some anywhere on the plot, some off-plot noise.
  task automatic random_point(input int w_lim, input int h_lim, input int fx, input int fy);
    int x, y, age, r;
    r = $urandom_range(0, 99);
    if (w_lim == 0 || h_lim == 0 || r < 15) begin
      x = $urandom;
      y = $urandom;
    end else if (r < 30) begin
      x = $urandom_range(0, w_lim - 1);
      y = $urandom_range(0, h_lim - 1);
    end else begin
      x = fx + $urandom_range(0, 1);
      y = fy + $urandom_range(0, 3);
      if (x >= w_lim)
        x = fx;
      if (y >= h_lim)
        y = fy;
    end
    age = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom;
    send_point(x, y, $urandom, age);
  endtask

  initial begin
    int phase, beats, empty_base, w_lim, h_lim, fx, fy, n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset plot size of 512 by 256 dots.
    // Equal age keeps the louder level, a younger point takes over the cell.
    send_point(0, 0, -4096, 65535);
    send_point(1, 0, 4095, 65535);
    send_point(0, 3, 100, 1000);
    send_point(1, 3, 50, 1000);
    // Last dot of the plot and a second cell.
    send_point(511, 255, 0, 0);
    send_point(2, 4, -1, 12345);
    // Points off the plot and negative coordinates are dropped.
    send_point(512, 0, 7, 7);
    send_point(0, 256, 7, 7);
    send_point(-1, 5, 7, 7);
    send_point(5, -1024, 7, 7);
    send_point(1023, -1, 7, 7);
    send_drain();
    send_drain();
    // A point behind the scan position waits for the next pass.
    send_point(0, 1, 7, 2);
    send_drain();
    send_drain();
    send_drain();
    wait_idle();

    // Random phases, one plot size each.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      write_plot(plot_w_tbl[phase], plot_h_tbl[phase]);
      calm = (phase % 3 == 1);
      w_lim = (plot_w_tbl[phase] > MAX_DOT_COLS_DEF) ? MAX_DOT_COLS_DEF : plot_w_tbl[phase];
      h_lim = (plot_h_tbl[phase] > MAX_DOT_ROWS_DEF) ? MAX_DOT_ROWS_DEF : plot_h_tbl[phase];
      empty_base = empties;
      if (phase == PRESSURE_PHASE)
        hold_request = 1'b1;
      beats = 0;
      while (beats < PHASE_BEATS) begin
        fx = 0;
        fy = 0;
        if (w_lim > 0 && h_lim > 0) begin
          fx = $urandom_range(0, w_lim - 1) & ~1;
          fy = $urandom_range(0, h_lim - 1) & ~3;
        end
        // A burst of points, then a burst of drains.
        n = $urandom_range(2, 12);
        repeat (n) random_point(w_lim, h_lim, fx, fy);
        beats += n;
        n = $urandom_range(1, 5);
        repeat (n) begin
          if (empties - empty_base >= EMPTY_CAP)
            random_point(w_lim, h_lim, fx, fy);
          else
            send_drain();
        end
        beats += n;
      end
      wait_idle();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### braille_cell_binner.f
+incdir+rtl/core
rtl/core/bcb_pkg.sv
rtl/core/bcb_ctrl.sv
rtl/core/bcb_datapath.sv
rtl/core/braille_cell_binner.sv
rtl/core/braille_cell_binner_chk.sv
tb/sv/braille_cell_binner_checker.sv
tb/sv/braille_cell_binner_tb.sv
